// ===== rtl/asrd_pkg.sv =====
// Shared types and constants for the analog stick radial deadzone block.
`timescale 1ns / 1ps

package asrd_pkg;

  localparam int unsigned SuW = 19;               // shared subtract/compare unit width

  localparam logic [14:0] AXIS_MAX = 15'h7FFF;
  localparam logic [7:0]  OUT_MAX  = 8'd127;

  typedef enum logic [2:0] {
    REG_DEADZONE     = 3'd0,
    REG_IN_LIMIT     = 3'd1,
    REG_OUT_LIMIT    = 3'd2,
    REG_FLIP_X       = 3'd3,
    REG_FLIP_Y       = 3'd4,
    REG_KEYS_ENABLED = 3'd5,
    REG_PAD_ENABLED  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic               pad_present;
    logic               key_left;
    logic               key_right;
    logic               key_up;
    logic               key_down;
    logic               focused;
  } sample_t;

  typedef struct packed {
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } result_t;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [14:0] in_limit;
    logic [6:0]  out_limit;
    logic        flip_x;
    logic        flip_y;
    logic        keys_enabled;
    logic        pad_enabled;
  } cfg_t;

  // sign and magnitude of one conditioned axis
  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } axis_t;

  typedef struct packed {
    logic           ge;
    logic [SuW-1:0] diff;
  } su_res_t;

endpackage

// ===== rtl/asrd_cond.sv =====
// Axis conditioning: clamp, invert, key override and focus gating.
`timescale 1ns / 1ps

module asrd_cond (
  input  asrd_pkg::sample_t sample,
  input  asrd_pkg::cfg_t    cfg,
  output asrd_pkg::axis_t   ax,
  output asrd_pkg::axis_t   ay
);

  function automatic asrd_pkg::axis_t cond_axis(
    input logic signed [15:0] raw,
    input logic               inv,
    input logic               live,
    input logic               kpos,
    input logic               kneg,
    input logic               ken,
    input logic               foc
  );
    asrd_pkg::axis_t a;
    logic [15:0]     n;
    a = '0;
    n = 16'(-raw);
    if (live) begin
      if (raw == 16'sh8000) begin
        a.mag = asrd_pkg::AXIS_MAX;
      end else if (raw[15]) begin
        a.mag = n[14:0];
      end else begin
        a.mag = raw[14:0];
      end
      a.neg = raw[15] ^ inv;
    end
    // a key wins only when strictly stronger than the stick
    if (ken && (kpos != kneg) && (a.mag != asrd_pkg::AXIS_MAX)) begin
      a.mag = asrd_pkg::AXIS_MAX;
      a.neg = kneg;
    end
    if (!foc) begin
      a = '0;
    end
    return a;
  endfunction

  logic live;

  assign live = cfg.pad_enabled & sample.pad_present;

  assign ax = cond_axis(sample.axis_x, cfg.flip_x, live, sample.key_right,
                        sample.key_left, cfg.keys_enabled, sample.focused);
  assign ay = cond_axis(sample.axis_y, cfg.flip_y, live, sample.key_up,
                        sample.key_down, cfg.keys_enabled, sample.focused);

endmodule

// ===== rtl/asrd_subu.sv =====
// Shared compare/subtract unit used by the square root and divide steps.
`timescale 1ns / 1ps

module asrd_subu (
  input  logic [asrd_pkg::SuW-1:0] a,
  input  logic [asrd_pkg::SuW-1:0] b,
  output asrd_pkg::su_res_t        res
);

  logic [asrd_pkg::SuW:0] d;

  assign d        = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~d[asrd_pkg::SuW];
  assign res.diff = d[asrd_pkg::SuW-1:0];

endmodule

// ===== rtl/analog_stick_radial_deadzone.sv =====
// Top level: sequencer, shared multiplier and registers of the stick mapper.
`timescale 1ns / 1ps

// Radial deadzone and rescaling of one analog stick sample.
// Input: raise start with a sample while busy is low; the sample is taken at
// that edge and busy rises in the next cycle.
// Output: result is valid for exactly one cycle while done is high. The
// receiver cannot stall; it must take the beat in that cycle.
// Config: cfg_valid/cfg_ready write channel, cfg_index selects the register
// (0 deadzone .. 6 pad_enabled), cfg_data is masked to the register width.
// cfg_ready is always high; write only while the block is idle.
// Sequence: when the stick is at or inside the deadzone, or in_limit does
// not exceed the deadzone, the divides are skipped and a zero result is
// given; done is high in the first cycle with busy low, and a new start is
// taken in that same cycle. The work is a 16-step restoring square root and
// three 8-step restoring divides, all run through one compare/subtract unit,
// plus one shared 16x16 multiplier; no new sample is taken while busy.
// Reset: synchronous, active high; the registers return to their defaults
// (deadzone 4096, input range 32767, output range 80, invert y, keys and pad
// enabled) and the sequencer goes idle with no result pending.

module analog_stick_radial_deadzone (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  asrd_pkg::sample_t   sample,
  output logic                done,
  output asrd_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SUM,
    S_SQRT,
    S_CHK,
    S_MUL,
    S_DLOAD,
    S_DIV
  } state_t;

  typedef enum logic [1:0] {
    PH_RAD,
    PH_X,
    PH_Y
  } phase_t;

  state_t                    state;
  phase_t                    phase;
  asrd_pkg::cfg_t            cfg;
  asrd_pkg::axis_t           ax_in;
  asrd_pkg::axis_t           ay_in;
  asrd_pkg::axis_t           ax;
  asrd_pkg::axis_t           ay;
  asrd_pkg::su_res_t         su;
  logic [asrd_pkg::SuW-1:0]  su_a;
  logic [asrd_pkg::SuW-1:0]  su_b;
  logic [15:0]               mul_a;
  logic [15:0]               mul_b;
  logic [31:0]               mul_p;
  logic [31:0]               prod;
  logic [29:0]               sumsq;
  logic [31:0]               rad_sh;
  logic [16:0]               rem;
  logic [15:0]               root;
  logic [7:0]                dlo;
  logic [15:0]               divisor;
  logic [7:0]                q;
  logic [7:0]                q_next;
  logic [3:0]                cnt;
  logic [14:0]               dif;
  logic [14:0]               span;
  logic [14:0]               cl;
  logic [6:0]                rad;
  logic [7:0]                qx;
  logic                      pass;

  function automatic logic signed [7:0] signed_out(input logic neg, input logic [7:0] qv);
    logic [7:0] m;
    m = (qv > asrd_pkg::OUT_MAX) ? asrd_pkg::OUT_MAX : qv;
    return neg ? 8'(-m) : m;
  endfunction

  asrd_cond u_cond (
    .sample (sample),
    .cfg    (cfg),
    .ax     (ax_in),
    .ay     (ay_in)
  );

  asrd_subu u_subu (
    .a   (su_a),
    .b   (su_b),
    .res (su)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX: begin
        mul_a = {1'b0, ax.mag};
        mul_b = {1'b0, ax.mag};
      end
      S_SQY: begin
        mul_a = {1'b0, ay.mag};
        mul_b = {1'b0, ay.mag};
      end
      S_MUL: begin
        unique case (phase)
          PH_RAD: begin
            mul_a = {1'b0, dif};
            mul_b = {9'b0, cfg.out_limit};
          end
          PH_X: begin
            mul_a = {1'b0, ax.mag};
            mul_b = {9'b0, rad};
          end
          PH_Y: begin
            mul_a = {1'b0, ay.mag};
            mul_b = {9'b0, rad};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared compare/subtract operands
  always_comb begin
    unique case (state)
      S_SQRT: begin
        su_a = {rem, rad_sh[31:30]};
        su_b = {1'b0, root, 2'b01};
      end
      S_DIV: begin
        su_a = {2'b0, rem[15:0], dlo[7]};
        su_b = {3'b0, divisor};
      end
      default: begin
        su_a = '0;
        su_b = '0;
      end
    endcase
  end

  assign q_next = {q[6:0], su.ge};
  assign pass   = (root > {1'b0, cfg.deadzone}) && (cfg.in_limit > cfg.deadzone);
  assign cl     = (root < {1'b0, cfg.in_limit}) ? root[14:0] : cfg.in_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_RAD;
      done             <= 1'b0;
      cfg.deadzone     <= 15'd4096;
      cfg.in_limit     <= 15'd32767;
      cfg.out_limit    <= 7'd80;
      cfg.flip_x       <= 1'b0;
      cfg.flip_y       <= 1'b1;
      cfg.keys_enabled <= 1'b1;
      cfg.pad_enabled  <= 1'b1;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          asrd_pkg::REG_DEADZONE:     cfg.deadzone     <= cfg_data[14:0];
          asrd_pkg::REG_IN_LIMIT:     cfg.in_limit     <= cfg_data[14:0];
          asrd_pkg::REG_OUT_LIMIT:    cfg.out_limit    <= cfg_data[6:0];
          asrd_pkg::REG_FLIP_X:       cfg.flip_x       <= cfg_data[0];
          asrd_pkg::REG_FLIP_Y:       cfg.flip_y       <= cfg_data[0];
          asrd_pkg::REG_KEYS_ENABLED: cfg.keys_enabled <= cfg_data[0];
          asrd_pkg::REG_PAD_ENABLED:  cfg.pad_enabled  <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            ax    <= ax_in;
            ay    <= ay_in;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          prod  <= mul_p;
          state <= S_SQY;
        end
        S_SQY: begin
          sumsq <= prod[29:0];
          prod  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          rad_sh <= {2'b0, sumsq} + prod;
          rem    <= '0;
          root   <= '0;
          cnt    <= '0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          rem    <= su.ge ? su.diff[16:0] : su_a[16:0];
          root   <= {root[14:0], su.ge};
          rad_sh <= {rad_sh[29:0], 2'b00};
          cnt    <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (pass) begin
            dif   <= cl - cfg.deadzone;
            span  <= cfg.in_limit - cfg.deadzone;
            phase <= PH_RAD;
            state <= S_MUL;
          end else begin
            result <= '0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          // quotient fits in 8 bits, so only the low byte is shifted through
          rem     <= {3'b0, prod[21:8]};
          dlo     <= prod[7:0];
          divisor <= (phase == PH_RAD) ? {1'b0, span} : root;
          q       <= '0;
          cnt     <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem <= su.ge ? su.diff[16:0] : su_a[16:0];
          q   <= q_next;
          dlo <= {dlo[6:0], 1'b0};
          cnt <= cnt + 4'd1;
          if (cnt[2:0] == 3'd7) begin
            unique case (phase)
              PH_RAD: begin
                rad   <= q_next[6:0];
                phase <= PH_X;
                state <= S_MUL;
              end
              PH_X: begin
                qx    <= q_next;
                phase <= PH_Y;
                state <= S_MUL;
              end
              default: begin
                result.stick_x <= signed_out(ax.neg, qx);
                result.stick_y <= signed_out(ay.neg, q_next);
                done           <= 1'b1;
                state          <= S_IDLE;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result beat only closes out work that was in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without work in flight");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted sample did not start work");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("one sample gave two result beats");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.stick_x != 8'sh80 && result.stick_y != 8'sh80))
    else $error("result outside +-127");

endmodule
